[design/assert_macros.svh]
// Assertion macros for the mesh builder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RGM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define RGM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rgm_pkg.sv]
// Shared types, constants and helpers for the remap grid mesh builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rgm_pkg;

    localparam int MAP_W      = 12;
    localparam int CROP_W     = 10;
    localparam int STEP_W     = 7;
    localparam int COORD_W    = 16;
    localparam int SCALE_W    = 18;
    localparam int SHIFT_W    = 4;
    localparam int VIEW_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_W      = 29;
    localparam int REM_W      = 13;
    localparam int DIV_CNT_W  = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int IN_DATA_W  = 8 * COORD_W;
    localparam int OUT_DATA_W = 4 * COORD_W;
    localparam int CORNERS_W  = 8 * COORD_W;

    localparam logic [MAP_W-1:0]  MAP_WIDTH_RST  = 12'd1280;
    localparam logic [MAP_W-1:0]  MAP_HEIGHT_RST = 12'd720;
    localparam logic [STEP_W-1:0] GRID_STEP_RST  = 7'd4;

    localparam logic [4:0]  FRAC_SHIFT   = 5'd16;
    localparam logic [15:0] Q14_ONE      = 16'd16384;
    localparam int          SCREEN_X_LIM = 49151;
    localparam int          SCREEN_Y_LIM = 49152;
    localparam logic [15:0] SCREEN_MAX   = 16'h7FFF;
    localparam logic [15:0] SCREEN_MIN   = 16'h8000;
    localparam logic [15:0] TEX_MAX      = 16'hFFFF;
    localparam logic [16:0] TEX_ONE      = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH,
        REG_MAP_HEIGHT,
        REG_CROP_LEFT,
        REG_CROP_RIGHT,
        REG_CROP_TOP,
        REG_CROP_BOTTOM,
        REG_GRID_STEP,
        REG_MIRROR
    } reg_idx_t;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_DIV,
        CFG_STORE
    } cfg_state_t;

    typedef enum logic [2:0] {
        JOB_VIEW_W,
        JOB_VIEW_H,
        JOB_MAP_W,
        JOB_MAP_H,
        JOB_COLS,
        JOB_ROWS
    } div_job_t;

    // Vertex slots of a cell: first triangle tl,bl,tr then second tr,bl,br.
    typedef enum logic [2:0] {
        V_T1_A,
        V_T1_B,
        V_T1_C,
        V_T2_A,
        V_T2_B,
        V_T2_C
    } vtx_slot_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } corner_t;

    // tl.x sits in the lowest bits, matching the input beat layout.
    typedef struct packed {
        corner_t br;
        corner_t tr;
        corner_t bl;
        corner_t tl;
    } corners_t;

    typedef struct packed {
        logic               ok;
        logic [SHIFT_W-1:0] n;
        logic [SCALE_W-1:0] value;
    } scale_t;

    typedef struct packed {
        logic [MAP_W-1:0]  map_width;
        logic [MAP_W-1:0]  map_height;
        logic [STEP_W-1:0] step;
    } front_cfg_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              mirror;
        scale_t            sx;
        scale_t            sy;
        scale_t            su;
        scale_t            sv;
    } back_cfg_t;

    function automatic logic [SHIFT_W-1:0] bit_len(input logic [MAP_W-1:0] d);
        logic [SHIFT_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (d[i]) begin
                n = SHIFT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[design/remap_grid_mesh_builder_top.sv]
// Top level of the remap grid mesh builder: config/scale unit, front end,
// cell queue and vertex back end. Depends on rgm_pkg and assert_macros.svh.
//
//  port group | dir | beat contents (low bits first)
//  s_*        | in  | one cell: tl_x, tl_y, bl_x, bl_y, tr_x, tr_y, br_x, br_y
//  m_*        | out | one vertex: screen_x, screen_y, texture_u, texture_v
//  cfg_*      | in  | register index and write data
//
// One cell beat per cycle in while s_tready is high; it yields 0, 3 or 6 vertex
// beats, one per cycle from the back end while m_tready allows.
// A cell's first vertex passes the queue entry, the select stage, the multiply
// stage and the output register. After reset and after each register write
// the shared serial divider runs six jobs with s_tready low.
// m_tready low with a beat held freezes the back end; the 4-entry cell queue
// keeps s_tready up until it fills.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module remap_grid_mesh_builder_top #(
    parameter int MAX_MAP_DIM = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tl_x, tl_y, bl_x, bl_y, tr_x, tr_y, br_x, br_y (16 b each)
    input  logic [rgm_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // screen_x, screen_y, texture_u, texture_v (16 b each)
    output logic [rgm_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // last_of_frame
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rgm_pkg::*;

    localparam int CW    = $clog2(MAX_MAP_DIM);
    localparam int PXW   = CW + STEP_W;
    localparam int REC_W = CORNERS_W + 2 * PXW + 3;

    front_cfg_t       fcfg;
    back_cfg_t        bcfg;
    logic [CW-1:0]    grid_cols, grid_rows;
    logic             cfg_busy, restart;
    logic             push, pop, head_valid, full;
    logic [REC_W-1:0] push_data, head_data;

    rgm_cfg #(
        .MAX_MAP_DIM (MAX_MAP_DIM),
        .CW          (CW)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fcfg      (fcfg),
        .bcfg      (bcfg),
        .grid_cols (grid_cols),
        .grid_rows (grid_rows),
        .busy      (cfg_busy),
        .restart   (restart)
    );

    rgm_front #(
        .CW    (CW),
        .PXW   (PXW),
        .REC_W (REC_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fcfg      (fcfg),
        .grid_cols (grid_cols),
        .grid_rows (grid_rows),
        .busy      (cfg_busy),
        .restart   (restart),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    rgm_fifo #(
        .W (REC_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (full)
    );

    rgm_back #(
        .PXW   (PXW),
        .REC_W (REC_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .bcfg       (bcfg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    `RGM_ASSERT_IMP(a_frame_end_closes_cell, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "frame end beat without cell end")
    `RGM_ASSERT_IMP(a_grid_has_scales, aclk, aresetn, !cfg_busy && (grid_cols != '0) && (grid_rows != '0), bcfg.sx.ok && bcfg.sy.ok, "nonempty grid without screen scales")
    `RGM_ASSERT_NEXT(a_push_lands, aclk, aresetn, push, head_valid, "queued cell record missing")

endmodule

[design/rgm_cfg.sv]
// Configuration registers and the shared serial divider that derives
// reciprocal scales and grid cell counts. Depends on rgm_pkg.
`timescale 1ns / 1ps

module rgm_cfg #(
    parameter int MAX_MAP_DIM = 2048,
    parameter int CW          = 11
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rgm_pkg::front_cfg_t               fcfg,
    output rgm_pkg::back_cfg_t                bcfg,
    output logic [CW-1:0]                     grid_cols,
    output logic [CW-1:0]                     grid_rows,
    output logic                              busy,
    output logic                              restart
);
    import rgm_pkg::*;

    localparam int CMP_W = ((CW > MAP_W) ? CW : MAP_W) + 1;

    logic [MAP_W-1:0]  map_width_reg, map_height_reg;
    logic [CROP_W-1:0] crop_left_reg, crop_right_reg, crop_top_reg, crop_bottom_reg;
    logic [STEP_W-1:0] grid_step_reg;
    logic              mirror_reg;

    cfg_state_t state_reg, state_next;
    div_job_t   job_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [MAP_W-1:0]     div_reg;
    logic                 ok_reg;

    scale_t sx_reg, sy_reg, su_reg, sv_reg;
    logic [CW-1:0] cols_reg, rows_reg;

    logic cfg_fire;
    logic do_load, do_div, do_store;

    logic signed [VIEW_W-1:0] view_w, view_h;
    logic                     view_w_pos, view_h_pos;
    logic [STEP_W-1:0]        step;

    logic [MAP_W-1:0]   ld_div, ld_plain;
    logic               ld_ok, ld_recip;
    logic [SHIFT_W-1:0] ld_n;
    logic [NUM_W-1:0]   ld_num;

    logic [REM_W-1:0] rem_sh, rem_next;
    logic             q_bit;

    scale_t            st_scale;
    logic [MAP_W-1:0]  st_q;
    logic [CMP_W-1:0]  st_q_ext, st_lim, st_cnt;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign restart   = cfg_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg   <= MAP_WIDTH_RST;
            map_height_reg  <= MAP_HEIGHT_RST;
            crop_left_reg   <= '0;
            crop_right_reg  <= '0;
            crop_top_reg    <= '0;
            crop_bottom_reg <= '0;
            grid_step_reg   <= GRID_STEP_RST;
            mirror_reg      <= 1'b0;
        end else if (cfg_fire) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data[MAP_W-1:0];
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_data[MAP_W-1:0];
                REG_CROP_LEFT:   crop_left_reg   <= cfg_data[CROP_W-1:0];
                REG_CROP_RIGHT:  crop_right_reg  <= cfg_data[CROP_W-1:0];
                REG_CROP_TOP:    crop_top_reg    <= cfg_data[CROP_W-1:0];
                REG_CROP_BOTTOM: crop_bottom_reg <= cfg_data[CROP_W-1:0];
                REG_GRID_STEP:   grid_step_reg   <= cfg_data[STEP_W-1:0];
                REG_MIRROR:      mirror_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        view_w = $signed({2'b00, map_width_reg}) - $signed({4'b0000, crop_left_reg})
                 - $signed({4'b0000, crop_right_reg});
        view_h = $signed({2'b00, map_height_reg}) - $signed({4'b0000, crop_top_reg})
                 - $signed({4'b0000, crop_bottom_reg});
        view_w_pos = !view_w[VIEW_W-1] && (view_w != '0);
        view_h_pos = !view_h[VIEW_W-1] && (view_h != '0);
        step = (grid_step_reg == '0) ? STEP_W'(1) : grid_step_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CFG_IDLE:  state_next = CFG_IDLE;
            CFG_LOAD:  state_next = ld_ok ? CFG_DIV : CFG_STORE;
            CFG_DIV:   state_next = (cnt_reg == DIV_CNT_W'(NUM_W - 1)) ? CFG_STORE : CFG_DIV;
            CFG_STORE: state_next = (job_reg == JOB_ROWS) ? CFG_IDLE : CFG_LOAD;
            default:   state_next = CFG_IDLE;
        endcase
        if (cfg_fire) begin
            state_next = CFG_LOAD;
        end
    end

    // Outputs of the sequencer
    always_comb begin
        do_load  = 1'b0;
        do_div   = 1'b0;
        do_store = 1'b0;
        busy     = 1'b1;
        unique case (state_reg)
            CFG_IDLE:  busy     = 1'b0;
            CFG_LOAD:  do_load  = 1'b1;
            CFG_DIV:   do_div   = 1'b1;
            CFG_STORE: do_store = 1'b1;
            default:   busy     = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CFG_LOAD;
            job_reg   <= JOB_VIEW_W;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                job_reg <= JOB_VIEW_W;
            end else if (do_store && job_reg != JOB_ROWS) begin
                job_reg <= div_job_t'(job_reg + 3'd1);
            end
        end
    end

    always_comb begin
        ld_div   = '0;
        ld_plain = '0;
        ld_ok    = 1'b0;
        ld_recip = 1'b1;
        unique case (job_reg)
            JOB_VIEW_W: begin
                ld_div = view_w[MAP_W-1:0];
                ld_ok  = view_w_pos;
            end
            JOB_VIEW_H: begin
                ld_div = view_h[MAP_W-1:0];
                ld_ok  = view_h_pos;
            end
            JOB_MAP_W: begin
                ld_div = map_width_reg;
                ld_ok  = (map_width_reg != '0);
            end
            JOB_MAP_H: begin
                ld_div = map_height_reg;
                ld_ok  = (map_height_reg != '0);
            end
            JOB_COLS: begin
                ld_div   = MAP_W'(step);
                ld_plain = view_w[MAP_W-1:0];
                ld_ok    = view_w_pos;
                ld_recip = 1'b0;
            end
            JOB_ROWS: begin
                ld_div   = MAP_W'(step);
                ld_plain = view_h[MAP_W-1:0];
                ld_ok    = view_h_pos;
                ld_recip = 1'b0;
            end
            default: ld_ok = 1'b0;
        endcase
        ld_n   = bit_len(ld_div);
        ld_num = ld_recip
               ? (NUM_W'(1) << ({1'b0, ld_n} + FRAC_SHIFT)) + NUM_W'(ld_div[MAP_W-1:1])
               : NUM_W'(ld_plain);
    end

    // One restoring step per cycle; quotient bits shift in behind the numerator.
    always_comb begin
        rem_sh   = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        q_bit    = (rem_sh >= {1'b0, div_reg});
        rem_next = q_bit ? (rem_sh - {1'b0, div_reg}) : rem_sh;
    end

    always_comb begin
        st_scale.ok    = ok_reg;
        st_scale.n     = bit_len(div_reg);
        st_scale.value = ok_reg ? num_reg[SCALE_W-1:0] : '0;
        st_q     = num_reg[MAP_W-1:0];
        st_q_ext = CMP_W'(st_q);
        st_lim   = CMP_W'(MAX_MAP_DIM - 1);
        if (!ok_reg || st_q == '0) begin
            st_cnt = '0;
        end else if ((st_q_ext - CMP_W'(1)) > st_lim) begin
            st_cnt = st_lim;
        end else begin
            st_cnt = st_q_ext - CMP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            ok_reg   <= 1'b0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            su_reg   <= '0;
            sv_reg   <= '0;
            cols_reg <= '0;
            rows_reg <= '0;
        end else begin
            if (do_load) begin
                ok_reg  <= ld_ok;
                cnt_reg <= '0;
            end
            if (do_div) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            if (do_store) begin
                unique case (job_reg)
                    JOB_VIEW_W: sx_reg   <= st_scale;
                    JOB_VIEW_H: sy_reg   <= st_scale;
                    JOB_MAP_W:  su_reg   <= st_scale;
                    JOB_MAP_H:  sv_reg   <= st_scale;
                    JOB_COLS:   cols_reg <= st_cnt[CW-1:0];
                    JOB_ROWS:   rows_reg <= st_cnt[CW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            div_reg <= ld_div;
            num_reg <= ld_ok ? ld_num : '0;
            rem_reg <= '0;
        end else if (do_div) begin
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign fcfg.map_width  = map_width_reg;
    assign fcfg.map_height = map_height_reg;
    assign fcfg.step       = step;
    assign bcfg.step       = step;
    assign bcfg.mirror     = mirror_reg;
    assign bcfg.sx         = sx_reg;
    assign bcfg.sy         = sy_reg;
    assign bcfg.su         = su_reg;
    assign bcfg.sv         = sv_reg;
    assign grid_cols       = cols_reg;
    assign grid_rows       = rows_reg;

endmodule

[design/rgm_front.sv]
// Front end: accepts cell beats, tracks the cell position, bounds-checks the
// corners and queues a cell record when it yields a triangle. Depends on rgm_pkg.
`timescale 1ns / 1ps

module rgm_front #(
    parameter int CW    = 11,
    parameter int PXW   = 18,
    parameter int REC_W = 167
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rgm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  rgm_pkg::front_cfg_t            fcfg,
    input  logic [CW-1:0]                  grid_cols,
    input  logic [CW-1:0]                  grid_rows,
    input  logic                           busy,
    input  logic                           restart,
    input  logic                           full,
    output logic                           push,
    output logic [REC_W-1:0]               push_data
);
    import rgm_pkg::*;

    typedef struct packed {
        corners_t       corners;
        logic [PXW-1:0] col_px;
        logic [PXW-1:0] row_px;
        logic           tri_a;
        logic           tri_b;
        logic           frame_end;
    } cell_rec_t;

    function automatic logic corner_in(input corner_t c, input logic [MAP_W-1:0] mw,
                                       input logic [MAP_W-1:0] mh, input logic closed_low);
        logic x_lo, y_lo, x_hi, y_hi;
        x_lo = !c.x[COORD_W-1] && (closed_low || (c.x != '0));
        y_lo = !c.y[COORD_W-1] && (closed_low || (c.y != '0));
        x_hi = $signed({c.x[COORD_W-1], c.x}) < $signed({1'b0, mw, 4'b0000});
        y_hi = $signed({c.y[COORD_W-1], c.y}) < $signed({1'b0, mh, 4'b0000});
        return x_lo && y_lo && x_hi && y_hi;
    endfunction

    logic [CW-1:0]  col_reg, row_reg;
    logic [PXW-1:0] col_px_reg, row_px_reg;

    corners_t  cin;
    cell_rec_t rec;
    logic      accept, grid_ok, mid_ok, col_wrap, row_wrap;

    assign s_tready = !busy && !full;
    assign accept   = s_tvalid && s_tready;
    assign cin      = corners_t'(s_tdata);
    assign grid_ok  = (grid_cols != '0) && (grid_rows != '0);
    assign col_wrap = ({1'b0, col_reg} + (CW+1)'(1)) >= {1'b0, grid_cols};
    assign row_wrap = ({1'b0, row_reg} + (CW+1)'(1)) >= {1'b0, grid_rows};

    always_comb begin
        mid_ok = corner_in(cin.bl, fcfg.map_width, fcfg.map_height, 1'b0)
              && corner_in(cin.tr, fcfg.map_width, fcfg.map_height, 1'b0);
        rec.corners   = cin;
        rec.col_px    = col_px_reg;
        rec.row_px    = row_px_reg;
        rec.tri_a     = mid_ok && corner_in(cin.tl, fcfg.map_width, fcfg.map_height, 1'b0);
        rec.tri_b     = mid_ok && corner_in(cin.br, fcfg.map_width, fcfg.map_height, 1'b1);
        rec.frame_end = col_wrap && row_wrap;
    end

    assign push      = accept && grid_ok && (rec.tri_a || rec.tri_b);
    assign push_data = rec;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg    <= '0;
            row_reg    <= '0;
            col_px_reg <= '0;
            row_px_reg <= '0;
        end else if (accept && grid_ok) begin
            if (!col_wrap) begin
                col_reg    <= col_reg + CW'(1);
                col_px_reg <= col_px_reg + PXW'(fcfg.step);
            end else begin
                col_reg    <= '0;
                col_px_reg <= '0;
                if (!row_wrap) begin
                    row_reg    <= row_reg + CW'(1);
                    row_px_reg <= row_px_reg + PXW'(fcfg.step);
                end else begin
                    row_reg    <= '0;
                    row_px_reg <= '0;
                end
            end
        end
    end

endmodule

[design/rgm_fifo.sv]
// Short cell-record queue between the front end and the vertex back end.
// Depends on rgm_pkg for its depth.
`timescale 1ns / 1ps

module rgm_fifo #(
    parameter int W = 167
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] head_data,
    output logic         full
);
    import rgm_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    logic [W-1:0]  mem [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (AW+1)'(FIFO_DEPTH));
    assign head_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

[design/rgm_back.sv]
// Back end: walks the vertices of the head cell record, scales them in a
// multiply stage and saturates them into the output register. Depends on rgm_pkg.
`timescale 1ns / 1ps

module rgm_back #(
    parameter int PXW   = 18,
    parameter int REC_W = 167
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            head_valid,
    input  logic [REC_W-1:0]                head_data,
    output logic                            pop,
    input  rgm_pkg::back_cfg_t              bcfg,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rgm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser
);
    import rgm_pkg::*;

    localparam int SP_W = PXW + SCALE_W;
    localparam int TP_W = COORD_W + SCALE_W;

    typedef struct packed {
        corners_t       corners;
        logic [PXW-1:0] col_px;
        logic [PXW-1:0] row_px;
        logic           tri_a;
        logic           tri_b;
        logic           frame_end;
    } cell_rec_t;

    cell_rec_t rec;
    vtx_slot_t vi_reg, cur, last_slot;
    logic      first_reg, en, vtx_last;
    logic [PXW-1:0] c1, r1, sel_cx, sel_ry;
    corner_t   sel_p;

    logic                      a_valid_reg, a_loc_reg, a_lof_reg;
    logic [PXW-1:0]            a_cx_reg, a_ry_reg;
    logic signed [COORD_W-1:0] a_px_reg, a_py_reg;

    logic              b_valid_reg, b_loc_reg, b_lof_reg, b_u_pos_reg, b_v_pos_reg;
    logic [SP_W-1:0]   b_xp_reg, b_yp_reg;
    logic [TP_W-1:0]   b_up_reg, b_vp_reg;

    logic                  m_valid_reg, m_last_reg, m_user_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [SP_W:0]  sx_sum, sx_q, sy_sum, sy_q;
    logic [TP_W:0]  tu_sum, tu_q, tv_sum, tv_q;
    logic [16:0]    tu_mir;
    logic [15:0]    sx_val, sy_val, u_val, v_val;

    assign rec       = cell_rec_t'(head_data);
    assign en        = !m_valid_reg || m_tready;
    assign cur       = first_reg ? (rec.tri_a ? V_T1_A : V_T2_A) : vi_reg;
    assign last_slot = rec.tri_b ? V_T2_C : V_T1_C;
    assign vtx_last  = (cur == last_slot);
    assign pop       = en && head_valid && vtx_last;
    assign c1        = rec.col_px + PXW'(bcfg.step);
    assign r1        = rec.row_px + PXW'(bcfg.step);

    always_comb begin
        unique case (cur) inside
            V_T1_A: begin
                sel_cx = rec.col_px;
                sel_ry = rec.row_px;
                sel_p  = rec.corners.tl;
            end
            V_T1_B, V_T2_B: begin
                sel_cx = rec.col_px;
                sel_ry = r1;
                sel_p  = rec.corners.bl;
            end
            V_T1_C, V_T2_A: begin
                sel_cx = c1;
                sel_ry = rec.row_px;
                sel_p  = rec.corners.tr;
            end
            V_T2_C: begin
                sel_cx = c1;
                sel_ry = r1;
                sel_p  = rec.corners.br;
            end
            default: begin
                sel_cx = rec.col_px;
                sel_ry = rec.row_px;
                sel_p  = rec.corners.tl;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            vi_reg    <= V_T1_A;
        end else if (en && head_valid) begin
            if (vtx_last) begin
                first_reg <= 1'b1;
            end else begin
                first_reg <= 1'b0;
                vi_reg    <= vtx_slot_t'(cur + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= head_valid;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_cx_reg  <= sel_cx;
            a_ry_reg  <= sel_ry;
            a_px_reg  <= sel_p.x;
            a_py_reg  <= sel_p.y;
            a_loc_reg <= vtx_last;
            a_lof_reg <= vtx_last && rec.frame_end;

            b_xp_reg    <= SP_W'(a_cx_reg) * SP_W'(bcfg.sx.value);
            b_yp_reg    <= SP_W'(a_ry_reg) * SP_W'(bcfg.sy.value);
            b_up_reg    <= TP_W'(a_px_reg[COORD_W-2:0]) * TP_W'(bcfg.su.value);
            b_vp_reg    <= TP_W'(a_py_reg[COORD_W-2:0]) * TP_W'(bcfg.sv.value);
            b_u_pos_reg <= !a_px_reg[COORD_W-1] && (a_px_reg != '0);
            b_v_pos_reg <= !a_py_reg[COORD_W-1] && (a_py_reg != '0);
            b_loc_reg   <= a_loc_reg;
            b_lof_reg   <= a_lof_reg;

            m_data_reg <= {v_val, u_val, sy_val, sx_val};
            m_last_reg <= b_loc_reg;
            m_user_reg <= b_lof_reg;
        end
    end

    // Rounding, normalizing shift and saturation of the four fields.
    always_comb begin
        sx_sum = {1'b0, b_xp_reg} + ((SP_W+1)'(1) << bcfg.sx.n);
        sx_q   = bcfg.sx.ok ? (sx_sum >> ({1'b0, bcfg.sx.n} + 5'd1)) : '0;
        sx_val = (sx_q > (SP_W+1)'(SCREEN_X_LIM)) ? SCREEN_MAX : (sx_q[15:0] - Q14_ONE);

        sy_sum = {1'b0, b_yp_reg} + ((SP_W+1)'(1) << bcfg.sy.n);
        sy_q   = bcfg.sy.ok ? (sy_sum >> ({1'b0, bcfg.sy.n} + 5'd1)) : '0;
        sy_val = (sy_q > (SP_W+1)'(SCREEN_Y_LIM)) ? SCREEN_MIN : (Q14_ONE - sy_q[15:0]);

        tu_sum = {1'b0, b_up_reg} + ((TP_W+1)'(1) << ({1'b0, bcfg.su.n} + 5'd3));
        tu_q   = (bcfg.su.ok && b_u_pos_reg) ? (tu_sum >> ({1'b0, bcfg.su.n} + 5'd4)) : '0;
        tu_mir = TEX_ONE - tu_q[16:0];
        if (bcfg.mirror) begin
            if (tu_q == '0) begin
                u_val = TEX_MAX;
            end else if (tu_q > (TP_W+1)'(TEX_ONE)) begin
                u_val = '0;
            end else begin
                u_val = tu_mir[15:0];
            end
        end else begin
            u_val = (tu_q > (TP_W+1)'(TEX_MAX)) ? TEX_MAX : tu_q[15:0];
        end

        tv_sum = {1'b0, b_vp_reg} + ((TP_W+1)'(1) << ({1'b0, bcfg.sv.n} + 5'd3));
        tv_q   = (bcfg.sv.ok && b_v_pos_reg) ? (tv_sum >> ({1'b0, bcfg.sv.n} + 5'd4)) : '0;
        v_val  = (tv_q > (TP_W+1)'(TEX_MAX)) ? TEX_MAX : tv_q[15:0];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

[tb/sv/tb_remap_grid_mesh_builder_top.sv]
`timescale 1ns / 1ps
// Testbench for remap_grid_mesh_builder_top: cell beats in, vertex beats checked against
// an in-bench mesh predictor. Depends on rgm_pkg and the block's RTL only.

module tb_remap_grid_mesh_builder_top;
    import rgm_pkg::*;

    localparam int MAX_DIM     = 2048;
    localparam int DRAIN_WAIT  = 64;
    localparam int LONG_HOLD   = 80;
    localparam int RANDOM_GOAL = 120;

    typedef struct {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] u;
        logic [15:0] v;
        logic        end_cell;
        logic        end_frame;
    } mesh_vertex_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    remap_grid_mesh_builder_top #(.MAX_MAP_DIM(MAX_DIM)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    int map_w, map_h, crop_l, crop_r, crop_t, crop_b, step_reg, mirror_on;
    int cur_col, cur_row;
    mesh_vertex_t pending_vertices[$];

    int mismatch_count = 0;
    int cells_sent = 0;
    int live_cells = 0;
    int vertices_seen = 0;
    int frames_seen = 0;
    int reg_writes = 0;

    int burst_left = 0;
    bit gapless = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int rx_hold = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int bits_needed(input longint d);
        int n;
        n = 0;
        while (d > 0) begin
            n++;
            d = d >> 1;
        end
        return n;
    endfunction

    function automatic longint recip_scale(input longint d);
        int n;
        longint num;
        if (d <= 0) return 0;
        n = bits_needed(d);
        num = (longint'(1) << (n + 16)) + d / 2;
        return (num / d) & 'h3FFFF;
    endfunction

    function automatic longint to_screen(input longint off, input longint d);
        int n;
        if (d <= 0 || off < 0) return 0;
        n = bits_needed(d);
        return (off * recip_scale(d) + (longint'(1) << n)) >> (n + 1);
    endfunction

    function automatic longint to_texture(input longint raw, input longint d);
        int n;
        if (d <= 0 || raw <= 0) return 0;
        n = bits_needed(d);
        return (raw * recip_scale(d) + (longint'(1) << (n + 3))) >> (n + 4);
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic int view_width();
        return map_w - crop_l - crop_r;
    endfunction

    function automatic int view_height();
        return map_h - crop_t - crop_b;
    endfunction

    function automatic int cell_pitch();
        return step_reg == 0 ? 1 : step_reg;
    endfunction

    function automatic int cells_along(input int view);
        int c;
        if (view <= 0) return 0;
        c = view / cell_pitch() - 1;
        return int'(clip(c, 0, MAX_DIM - 1));
    endfunction

    function automatic bit grid_live();
        return cells_along(view_width()) > 0 && cells_along(view_height()) > 0;
    endfunction

    function automatic bit corner_in(input longint x, input longint y, input bit closed);
        bit lo;
        lo = closed ? (x >= 0 && y >= 0) : (x > 0 && y > 0);
        return lo && x < 16 * longint'(map_w) && y < 16 * longint'(map_h);
    endfunction

    function automatic mesh_vertex_t make_vertex(input longint cx, input longint ry,
                                                 input longint px, input longint py);
        mesh_vertex_t vx;
        longint sx, sy, u, v;
        sx = to_screen(cx, view_width()) - 16384;
        sy = 16384 - to_screen(ry, view_height());
        u = to_texture(px, map_w);
        v = to_texture(py, map_h);
        if (mirror_on != 0) u = 65536 - u;
        vx.sx = 16'(clip(sx, -32768, 32767));
        vx.sy = 16'(clip(sy, -32768, 32767));
        vx.u = 16'(clip(u, 0, 65535));
        vx.v = 16'(clip(v, 0, 65535));
        vx.end_cell = 1'b0;
        vx.end_frame = 1'b0;
        return vx;
    endfunction

    function automatic void build_cell_vertices(input corners_t cell_in);
        mesh_vertex_t vs[$];
        int ncol, nrow;
        longint s, c0, c1, r0, r1;
        longint tlx, tly, blx, bly, trx, try_, brx, bry;
        ncol = cells_along(view_width());
        nrow = cells_along(view_height());
        if (ncol <= 0 || nrow <= 0) return;
        live_cells++;
        tlx = cell_in.tl.x; tly = cell_in.tl.y;
        blx = cell_in.bl.x; bly = cell_in.bl.y;
        trx = cell_in.tr.x; try_ = cell_in.tr.y;
        brx = cell_in.br.x; bry = cell_in.br.y;
        s = cell_pitch();
        c0 = cur_col * s; c1 = c0 + s;
        r0 = cur_row * s; r1 = r0 + s;
        if (corner_in(blx, bly, 1'b0) && corner_in(trx, try_, 1'b0)) begin
            if (corner_in(tlx, tly, 1'b0)) begin
                vs.push_back(make_vertex(c0, r0, tlx, tly));
                vs.push_back(make_vertex(c0, r1, blx, bly));
                vs.push_back(make_vertex(c1, r0, trx, try_));
            end
            if (corner_in(brx, bry, 1'b1)) begin
                vs.push_back(make_vertex(c1, r0, trx, try_));
                vs.push_back(make_vertex(c0, r1, blx, bly));
                vs.push_back(make_vertex(c1, r1, brx, bry));
            end
        end
        if (vs.size() > 0) begin
            vs[vs.size() - 1].end_cell = 1'b1;
            vs[vs.size() - 1].end_frame = (cur_col >= ncol - 1) && (cur_row >= nrow - 1);
        end
        foreach (vs[i]) pending_vertices.push_back(vs[i]);
        if (cur_col + 1 < ncol) begin
            cur_col++;
        end else begin
            cur_col = 0;
            cur_row = (cur_row + 1 < nrow) ? cur_row + 1 : 0;
        end
    endfunction

    function automatic void apply_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_MAP_WIDTH:   map_w = d[MAP_W-1:0];
            REG_MAP_HEIGHT:  map_h = d[MAP_W-1:0];
            REG_CROP_LEFT:   crop_l = d[CROP_W-1:0];
            REG_CROP_RIGHT:  crop_r = d[CROP_W-1:0];
            REG_CROP_TOP:    crop_t = d[CROP_W-1:0];
            REG_CROP_BOTTOM: crop_b = d[CROP_W-1:0];
            REG_GRID_STEP:   step_reg = d[STEP_W-1:0];
            REG_MIRROR:      mirror_on = d[0];
            default: ;
        endcase
        cur_col = 0;
        cur_row = 0;
        reg_writes++;
    endfunction

    function automatic void field_check(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d (%h) got %0d (%h)", $time, name,
                     exp_val, exp_val, act_val, act_val);
            mismatch_count++;
        end
    endfunction

    function automatic void check_vertex_beat();
        mesh_vertex_t ev;
        vertices_seen++;
        if (m_tuser) frames_seen++;
        if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected vertex beat, expected none got %h", $time, m_tdata);
            mismatch_count++;
            return;
        end
        ev = pending_vertices.pop_front();
        field_check("screen_x", ev.sx, m_tdata[15:0]);
        field_check("screen_y", ev.sy, m_tdata[31:16]);
        field_check("texture_u", ev.u, m_tdata[47:32]);
        field_check("texture_v", ev.v, m_tdata[63:48]);
        field_check("last_of_cell", 16'(ev.end_cell), 16'(m_tlast));
        field_check("last_of_frame", 16'(ev.end_frame), 16'(m_tuser));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_reg(reg_idx_t'(cfg_index), cfg_data);
            if (m_tvalid && m_tready) check_vertex_beat();
            if (s_tvalid && s_tready) begin
                cells_sent++;
                build_cell_vertices(corners_t'(s_tdata));
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold on request
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            rx_hold <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(8, 64);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // let the monitor log the last accepted cell beat before the pending queue is checked
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        wait_idle();
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input int mw, input int mh, input int cl, input int cr,
                            input int ct, input int cb, input int st, input int mir);
        write_reg(REG_MAP_WIDTH, mw);
        write_reg(REG_MAP_HEIGHT, mh);
        write_reg(REG_CROP_LEFT, cl);
        write_reg(REG_CROP_RIGHT, cr);
        write_reg(REG_CROP_TOP, ct);
        write_reg(REG_CROP_BOTTOM, cb);
        write_reg(REG_GRID_STEP, st);
        write_reg(REG_MIRROR, mir);
    endtask

    task automatic send_cell(input corners_t cell_in);
        s_tdata <= cell_in;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (!gapless) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic corners_t make_cell(input int tlx, input int tly, input int blx,
                                           input int bly, input int trx, input int try_,
                                           input int brx, input int bry);
        corners_t c;
        c.tl.x = 16'(tlx); c.tl.y = 16'(tly);
        c.bl.x = 16'(blx); c.bl.y = 16'(bly);
        c.tr.x = 16'(trx); c.tr.y = 16'(try_);
        c.br.x = 16'(brx); c.br.y = 16'(bry);
        return c;
    endfunction

    // mostly inside the image, sometimes on or past an edge, or any 16-bit value
    function automatic logic [15:0] pick_coord(input longint lim, input bit closed);
        longint hi;
        hi = (lim - 1 > 32767) ? 32767 : lim - 1;
        if (hi >= 1 && $urandom_range(0, 19) < 17)
            return 16'($urandom_range(closed ? 0 : 1, int'(hi)));
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return (lim > 32767) ? 16'h7FFF : 16'(lim);
            2: return 16'(hi);
            3: return 16'(-$urandom_range(1, 32768));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic corners_t random_cell();
        longint lx, ly;
        lx = 16 * longint'(map_w);
        ly = 16 * longint'(map_h);
        return make_cell(pick_coord(lx, 0), pick_coord(ly, 0), pick_coord(lx, 0),
                         pick_coord(ly, 0), pick_coord(lx, 0), pick_coord(ly, 0),
                         pick_coord(lx, 1), pick_coord(ly, 1));
    endfunction

    task automatic test_reset_defaults();
        send_cell(make_cell(1, 1, 1, 11519, 20479, 1, 0, 0));
        send_cell(make_cell(-32768, 5, 16, 8000, 9000, 16, 20479, 11519));
    endtask

    // 3x2 cells: each corner rule and both frame-end cases
    task automatic test_bounds_and_frame();
        corners_t full;
        full = make_cell(16, 16, 16, 300, 400, 16, 400, 300);
        set_view(32, 24, 0, 0, 0, 0, 8, 0);
        send_cell(full);
        send_cell(make_cell(511, 1, 1, 383, 511, 383, 512, 100));
        send_cell(make_cell(0, 50, 20, 200, 300, 20, 0, 0));
        send_cell(make_cell(16, 16, -16, 100, 400, 16, 400, 300));
        send_cell(make_cell(32767, 32767, 16, 300, 100, 384, -32768, -32768));
        send_cell(make_cell(1, 1, 1, 383, 511, 1, 511, 383));
        repeat (5) send_cell(full);
        send_cell(make_cell(16, 16, 16, 384, 400, 16, 400, 300));
    endtask

    task automatic test_mirror_and_crop();
        write_reg(REG_MIRROR, 1);
        write_reg(REG_CROP_LEFT, 3);
        write_reg(REG_CROP_RIGHT, 2);
        write_reg(REG_CROP_TOP, 1);
        write_reg(REG_CROP_BOTTOM, 4);
        send_cell(make_cell(1, 1, 1, 383, 511, 1, 511, 383));
        send_cell(make_cell(256, 192, 256, 192, 256, 192, 256, 192));
    endtask

    task automatic test_empty_grid();
        write_reg(REG_MAP_WIDTH, 0);
        send_cell(make_cell(16, 16, 16, 100, 100, 16, 100, 100));
        send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0));
        write_reg(REG_MAP_WIDTH, 12);
        send_cell(make_cell(16, 16, 16, 100, 100, 16, 100, 100));
    endtask

    task automatic test_step_extremes();
        set_view(2, 2, 0, 0, 0, 0, 0, 0);
        send_cell(make_cell(1, 1, 1, 31, 31, 1, 31, 31));
        set_view(4095, 2048, 1023, 0, 1023, 0, 127, 1);
        send_cell(make_cell(16, 16, 16, 32767, 32767, 16, 32767, 32767));
        send_cell(make_cell(65519 - 65536, 1, 1000, 2000, 3000, 4000, 5000, 6000));
    endtask

    task automatic test_output_backpressure();
        set_view(64, 64, 0, 0, 0, 0, 8, 0);
        hold_requests <= hold_requests + 1;
        gapless = 1'b1;
        repeat (12) send_cell(make_cell(16, 16, 16, 1000, 1000, 16, 1000, 1000));
        gapless = 1'b0;
        wait_idle();
    endtask

    task automatic random_phase(input int n_cells);
        int s, ncol, nrow, cl, cr, ct, cb, mw, mh, st;
        if ($urandom_range(0, 4) != 0) begin
            s = $urandom_range(1, 8);
            cl = $urandom_range(0, 6); cr = $urandom_range(0, 6);
            ct = $urandom_range(0, 6); cb = $urandom_range(0, 6);
            ncol = $urandom_range(1, 5);
            nrow = $urandom_range(1, 4);
            mw = s * (ncol + 1) + $urandom_range(0, s - 1) + cl + cr;
            mh = s * (nrow + 1) + $urandom_range(0, s - 1) + ct + cb;
            st = (s == 1 && $urandom_range(0, 1) == 1) ? 0 : s;
        end else begin
            mw = $urandom_range(2, 2048);
            mh = $urandom_range(2, 2048);
            cl = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 64);
            cr = $urandom_range(0, 64);
            ct = $urandom_range(0, 64);
            cb = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 64);
            st = $urandom_range(0, 64);
        end
        set_view(mw, mh, cl, cr, ct, cb, st, $urandom_range(0, 1));
        repeat (n_cells) send_cell(random_cell());
    endtask

    task automatic test_random_frames();
        int start;
        start = live_cells;
        while (live_cells - start < RANDOM_GOAL) random_phase($urandom_range(12, 30));
        wait_idle();
    endtask

    initial begin
        map_w = MAP_WIDTH_RST;
        map_h = MAP_HEIGHT_RST;
        crop_l = 0; crop_r = 0; crop_t = 0; crop_b = 0;
        step_reg = GRID_STEP_RST;
        mirror_on = 0;
        cur_col = 0;
        cur_row = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_bounds_and_frame();
        test_mirror_and_crop();
        test_empty_grid();
        test_step_extremes();
        test_output_backpressure();
        test_random_frames();
        wait_idle();

        $display("Sent %0d cell beats (%0d in a live grid) over %0d register writes.",
                 cells_sent, live_cells, reg_writes);
        $display("Checked %0d vertex beats, %0d of them closing a frame.",
                 vertices_seen, frames_seen);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
